// ===== sv/pat_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Shared types and constants of the paged address translator.
// No dependencies; imported by pat_alloc, pat_ctrl, the top level and the bench.

package pat_pkg;

	localparam int NUM_TABLES_DEF = 4;
	localparam int PAGE_SHIFT_DEF = 16;

	localparam int TID_W       = 4;   // table id field width
	localparam int CNT_W       = 5;   // counts up to 16 tables
	localparam int MEM_BYTES_W = 33;

	localparam logic [MEM_BYTES_W-1:0] MEM_BYTES_RST = 33'h1_0000_0000;

	// command codes
	localparam logic [2:0] CMD_CREATE    = 3'd0;
	localparam logic [2:0] CMD_DESTROY   = 3'd1;
	localparam logic [2:0] CMD_LOAD      = 3'd2;
	localparam logic [2:0] CMD_MAP       = 3'd3;
	localparam logic [2:0] CMD_UNMAP     = 3'd4;
	localparam logic [2:0] CMD_GET       = 3'd5;
	localparam logic [2:0] CMD_TRANSLATE = 3'd6;

	// status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_INVALID   = 3'd1;
	localparam logic [2:0] ST_BADADDR   = 3'd2;
	localparam logic [2:0] ST_FAULT     = 3'd3;
	localparam logic [2:0] ST_EXHAUSTED = 3'd4;

	typedef struct packed {
		logic [2:0]  command;
		logic [7:0]  table_index;
		logic [31:0] vaddr;
		logic [31:0] phys_offset;
		logic [31:0] prot;
		logic        wr_access;
	} in_t;

	typedef struct packed {
		logic [2:0]       status;
		logic [TID_W-1:0] table_out;
		logic [31:0]      phys_out;
		logic [31:0]      entry_prot;
	} out_t;

	// table id allocator requests
	typedef struct packed {
		logic             pop;
		logic             fresh;
		logic             push;
		logic [TID_W-1:0] push_id;
	} alloc_op_t;

	typedef struct packed {
		logic [CNT_W-1:0] created;
		logic [CNT_W-1:0] count;
		logic [TID_W-1:0] top_id;
	} alloc_stat_t;

endpackage

`default_nettype wire

// ===== sv/pat_page_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Page entry store: one write port, one read port, registered read data.
// No package dependencies.

module pat_page_mem #(
	parameter int ADDR_W = 18,
	parameter int DATA_W = 49,
	parameter int DEPTH  = 262144
) (
	input  wire logic              clk,
	input  wire logic              rd_en,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output logic      [DATA_W-1:0] rd_data,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [DATA_W-1:0] wr_data
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== sv/pat_alloc.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Table id allocator: fresh id counter plus LIFO of destroyed ids.
// Depends on pat_pkg.

module pat_alloc
	import pat_pkg::*;
#(
	parameter int NUM_TABLES = NUM_TABLES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire alloc_op_t   op,
	output alloc_stat_t      stat
);

	localparam int SW = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;

	logic [TID_W-1:0] stack_q [NUM_TABLES];
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] created_q;
	logic [CNT_W-1:0] count_dec;

	assign count_dec = count_q - CNT_W'(1);

	assign stat.created = created_q;
	assign stat.count   = count_q;
	assign stat.top_id  = stack_q[count_dec[SW-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			created_q <= '0;
		end else begin
			if (op.pop) begin
				count_q <= count_dec;
			end else if (op.push) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (op.fresh) begin
				created_q <= created_q + CNT_W'(1);
			end
		end
	end

	// stack entries hold no reset; only entries below the count are used
	always_ff @(posedge clk) begin
		if (op.push) begin
			stack_q[count_q[SW-1:0]] <= op.push_id;
		end
	end

endmodule

`default_nettype wire

// ===== sv/pat_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Command sequencer: reads the page entry, decides, writes back, sweeps
// tables clean on fresh create and destroy. Depends on pat_pkg.

module pat_ctrl
	import pat_pkg::*;
#(
	parameter int NUM_TABLES = NUM_TABLES_DEF,
	parameter int PAGE_SHIFT = PAGE_SHIFT_DEF,
	localparam int TW = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1,
	localparam int PW = 32 - PAGE_SHIFT,
	localparam int EW = 1 + PW + 32,
	localparam int AW = TW + PW
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire in_t                    in_data,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output out_t                        out_data,
	input  wire logic [MEM_BYTES_W-1:0] mem_bytes,
	output alloc_op_t                   alloc_op,
	input  wire alloc_stat_t            alloc_stat,
	output logic                        rd_en,
	output logic [TW+PW-1:0]            rd_addr,
	input  wire logic [1+PW+32-1:0]     rd_data,
	output logic                        wr_en,
	output logic [TW+PW-1:0]            wr_addr,
	output logic [1+PW+32-1:0]          wr_data
);

	typedef enum logic [1:0] {S_IDLE, S_EXEC, S_CLEAR, S_RESP} state_t;

	state_t          state_q;
	in_t             req_q;
	out_t            res_q;
	out_t            out_q;
	logic            out_valid_q;
	logic [TW-1:0]   active_q;
	logic [TW-1:0]   clr_tbl_q;
	logic [PW-1:0]   clr_page_q;

	// entry fields from the read port
	logic            rd_vld;
	logic [PW-1:0]   rd_frame;
	logic [31:0]     rd_prot;

	logic            tbl_ok, act_ok, misal, over, perm;
	logic [MEM_BYTES_W-1:0] page_end;
	logic [TW-1:0]   sel_tbl;
	logic [AW-1:0]   ex_addr;

	out_t            ex_res;
	logic            ex_wr;
	logic [EW-1:0]   ex_wdata;
	logic            ex_clr;
	logic [TW-1:0]   ex_clr_tbl;
	logic            ex_load;
	alloc_op_t       ex_aop;
	logic            out_free;
	logic            out_take;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign out_free  = !out_valid_q || out_ready;
	// result register loads this cycle
	assign out_take  = out_free && (((state_q == S_EXEC) && !ex_clr) || (state_q == S_RESP));

	// read issued on the accept edge
	assign sel_tbl = (in_data.command == CMD_TRANSLATE) ? active_q
	                                                    : in_data.table_index[TW-1:0];
	assign rd_en   = in_valid && in_ready;
	assign rd_addr = {sel_tbl, in_data.vaddr[31 -: PW]};

	assign rd_vld   = rd_data[EW-1];
	assign rd_frame = rd_data[32 +: PW];
	assign rd_prot  = rd_data[31:0];

	assign ex_addr  = {req_q.table_index[TW-1:0], req_q.vaddr[31 -: PW]};
	assign tbl_ok   = req_q.table_index < 8'(alloc_stat.created);
	assign act_ok   = CNT_W'(active_q) < alloc_stat.created;
	assign misal    = (|req_q.vaddr[PAGE_SHIFT-1:0]) ||
	                  (|req_q.phys_offset[PAGE_SHIFT-1:0]);
	assign page_end = {1'b0, req_q.phys_offset} + (MEM_BYTES_W'(1) << PAGE_SHIFT);
	assign over     = page_end > mem_bytes;
	assign perm     = req_q.wr_access ? rd_prot[1] : rd_prot[0];

	always_comb begin
		ex_res        = '0;
		ex_res.status = ST_INVALID;
		ex_wr         = 1'b0;
		ex_wdata      = '0;
		ex_clr        = 1'b0;
		ex_clr_tbl    = req_q.table_index[TW-1:0];
		ex_load       = 1'b0;
		ex_aop        = '0;
		case (req_q.command)
			CMD_CREATE: begin
				if (alloc_stat.count != '0) begin
					ex_aop.pop       = 1'b1;
					ex_res.status    = ST_OK;
					ex_res.table_out = alloc_stat.top_id;
				end else if (alloc_stat.created < CNT_W'(NUM_TABLES)) begin
					// fresh table: sweep it before first use
					ex_aop.fresh     = 1'b1;
					ex_res.status    = ST_OK;
					ex_res.table_out = alloc_stat.created[TID_W-1:0];
					ex_clr           = 1'b1;
					ex_clr_tbl       = alloc_stat.created[TW-1:0];
				end else begin
					ex_res.status = ST_EXHAUSTED;
				end
			end
			CMD_DESTROY: begin
				if (tbl_ok && (alloc_stat.count < CNT_W'(NUM_TABLES))) begin
					ex_aop.push    = 1'b1;
					ex_aop.push_id = req_q.table_index[TID_W-1:0];
					ex_clr         = 1'b1;
					ex_res.status  = ST_OK;
				end
			end
			CMD_LOAD: begin
				if (tbl_ok) begin
					ex_load       = 1'b1;
					ex_res.status = ST_OK;
				end
			end
			CMD_MAP: begin
				if (!tbl_ok || misal) begin
					ex_res.status = ST_INVALID;
				end else if (over) begin
					ex_res.status = ST_BADADDR;
				end else begin
					ex_wr         = 1'b1;
					ex_wdata      = {1'b1, req_q.phys_offset[31 -: PW], req_q.prot};
					ex_res.status = ST_OK;
				end
			end
			CMD_UNMAP, CMD_GET: begin
				if (!tbl_ok) begin
					ex_res.status = ST_INVALID;
				end else if (!rd_vld) begin
					ex_res.status = ST_BADADDR;
				end else begin
					ex_res.status     = ST_OK;
					ex_res.phys_out   = {rd_frame, {PAGE_SHIFT{1'b0}}};
					ex_res.entry_prot = rd_prot;
					ex_wr             = (req_q.command == CMD_UNMAP);
				end
			end
			CMD_TRANSLATE: begin
				if (!rd_vld || !act_ok || !perm) begin
					ex_res.status = ST_FAULT;
				end else begin
					ex_res.status   = ST_OK;
					ex_res.phys_out = {rd_frame, req_q.vaddr[PAGE_SHIFT-1:0]};
				end
			end
			default: begin
				ex_res.status = ST_INVALID;
			end
		endcase
	end

	assign alloc_op = (state_q == S_EXEC) ? ex_aop : '0;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = ex_addr;
		wr_data = ex_wdata;
		case (state_q)
			S_EXEC: begin
				wr_en = ex_wr;
			end
			S_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = {clr_tbl_q, clr_page_q};
				wr_data = '0;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			req_q       <= '0;
			res_q       <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
			active_q    <= '0;
			clr_tbl_q   <= '0;
			clr_page_q  <= '0;
		end else begin
			if (out_take) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						req_q   <= in_data;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (ex_load) begin
						active_q <= req_q.table_index[TW-1:0];
					end
					if (ex_clr) begin
						res_q      <= ex_res;
						clr_tbl_q  <= ex_clr_tbl;
						clr_page_q <= '0;
						state_q    <= S_CLEAR;
					end else if (out_free) begin
						out_q   <= ex_res;
						state_q <= S_IDLE;
					end else begin
						res_q   <= ex_res;
						state_q <= S_RESP;
					end
				end
				S_CLEAR: begin
					clr_page_q <= clr_page_q + PW'(1);
					if (&clr_page_q) begin
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					if (out_free) begin
						out_q   <= res_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== sv/paged_address_translator_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Paged address translator, top level. Depends on pat_pkg, pat_page_mem,
// pat_alloc and pat_ctrl.
//
// Up to NUM_TABLES single-level page tables over a 32-bit virtual space,
// pages of 2^PAGE_SHIFT bytes. Commands (create, destroy, load, map, unmap,
// get, translate) arrive as in_data beats on a valid/ready channel; each
// beat yields exactly one out_data beat, in order.
//
// Timing: one command is in flight at a time. A beat is accepted in the
// idle state, the page entry is read from the single-port-read entry RAM
// into its registered read data, and the result is registered as the
// execute state ends. A create that hands out a fresh id and a successful
// destroy sweep the table clean, one entry per cycle. No clearing pass runs
// after reset: a table is swept when its id is first created, and tables
// never created are treated as empty.
//
// The result register lets the next command be accepted while the previous
// result is still waiting; if the receiver stalls with that register full,
// the new result parks and no further command is taken until it drains.
// Reset (arst_n low) empties the id allocator, sets the active table to
// id 0 and memory_bytes to 2^32; page entries persist. cfg_data (memory_bytes)
// is always ready and should be written only while the block is idle.

module paged_address_translator_top
	import pat_pkg::*;
#(
	parameter int NUM_TABLES = NUM_TABLES_DEF,
	parameter int PAGE_SHIFT = PAGE_SHIFT_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire in_t                    in_data,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output out_t                        out_data,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [MEM_BYTES_W-1:0] cfg_data
);

	localparam int TW    = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
	localparam int PW    = 32 - PAGE_SHIFT;
	localparam int EW    = 1 + PW + 32;          // valid, frame, protection
	localparam int AW    = TW + PW;
	localparam int DEPTH = NUM_TABLES * (2 ** PW);

	logic [MEM_BYTES_W-1:0] mem_bytes_q;
	alloc_op_t              alloc_op;
	alloc_stat_t            alloc_stat;
	logic                   rd_en;
	logic [AW-1:0]          rd_addr;
	logic [EW-1:0]          rd_data;
	logic                   wr_en;
	logic [AW-1:0]          wr_addr;
	logic [EW-1:0]          wr_data;

	// physical memory size register; writes are never back-pressured
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_bytes_q <= MEM_BYTES_RST;
		end else if (cfg_valid) begin
			mem_bytes_q <= cfg_data;
		end
	end

	pat_ctrl #(
		.NUM_TABLES (NUM_TABLES),
		.PAGE_SHIFT (PAGE_SHIFT)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.mem_bytes  (mem_bytes_q),
		.alloc_op   (alloc_op),
		.alloc_stat (alloc_stat),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.rd_data    (rd_data),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data)
	);

	pat_alloc #(
		.NUM_TABLES (NUM_TABLES)
	) u_alloc (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (alloc_op),
		.stat   (alloc_stat)
	);

	pat_page_mem #(
		.ADDR_W (AW),
		.DATA_W (EW),
		.DEPTH  (DEPTH)
	) u_page_mem (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for paged_address_translator_top: directed and random
// command beats checked against an in-bench page table predictor. Needs pat_pkg.

module tb_top;
	import pat_pkg::*;

	localparam int NUM_TABLES = NUM_TABLES_DEF;
	localparam int PAGE_SHIFT = PAGE_SHIFT_DEF;
	localparam int PAGE_BITS  = 32 - PAGE_SHIFT;
	localparam logic [31:0] PAGE_MASK  = (32'd1 << PAGE_SHIFT) - 32'd1;
	localparam logic [33:0] PAGE_BYTES = 34'd1 << PAGE_SHIFT;
	localparam logic [2:0]  CMD_UNUSED = 3'd7;   // no such command: always invalid
	// a table sweep has no beat on any channel; allow for three sweeps in a row
	localparam int WATCHDOG_LIMIT = 200000;
	localparam int LONG_STALL     = 400;

	typedef enum logic [1:0] {RX_STREAM, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_t;

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_t  in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [MEM_BYTES_W-1:0] cfg_data = '0;

	paged_address_translator_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// Predictor state: mirrors the block's tables, id allocator,
	// active table and memory size. Page entries are kept sparse,
	// keyed by {table id, page number}; a missing key is an invalid entry.
	// ---------------------------------------------------------------
	int unsigned      tbl_made   = 0;
	logic [TID_W-1:0] free_ids [NUM_TABLES];
	int unsigned      free_depth = 0;
	logic [TID_W-1:0] cur_table  = '0;
	logic [MEM_BYTES_W-1:0] mem_limit = MEM_BYTES_RST;
	logic [31:0] page_off  [int unsigned];
	logic [31:0] page_prot [int unsigned];

	out_t  outcome_q [$];      // expected result beats, oldest first
	in_t   cmd_backlog [$];    // command beats waiting for the driver
	int    cmds_unanswered = 0;
	int    mismatches = 0;

	// Stimulus-side view of the allocator, so the generator knows which
	// destroys would succeed (each one costs a full table sweep).
	int unsigned gen_made = 0;
	int unsigned gen_free = 0;
	int          destroys_left = 0;
	logic [MEM_BYTES_W-1:0] gen_mem = MEM_BYTES_RST;

	logic in_fire  = 1'b0;
	logic cfg_fire = 1'b0;
	int   quiet_cycles = 0;

	// driver and receiver pacing
	int       gap_left = 0;
	int       burst_left = 1;
	bit       stall_req = 1'b0;
	bit       stall_seen = 1'b0;
	int       stall_left = 0;
	rx_mode_t rx_mode = RX_STREAM;
	int       mode_left = 0;

	function automatic int unsigned entry_key(logic [TID_W-1:0] tid, logic [31:0] va);
		return (32'(tid) << PAGE_BITS) | (va >> PAGE_SHIFT);
	endfunction

	// Applies one command to the predictor state and returns its result beat.
	function automatic out_t page_table_outcome(in_t c);
		out_t r;
		logic known;
		logic [TID_W-1:0] tid;
		int unsigned key;
		int unsigned doomed [$];
		r = '0;
		r.status = ST_INVALID;
		known = (32'(c.table_index) < tbl_made);
		tid = c.table_index[TID_W-1:0];
		key = entry_key(tid, c.vaddr);
		case (c.command)
		CMD_CREATE: begin
			if (free_depth > 0) begin
				free_depth--;
				r.table_out = free_ids[free_depth];
				r.status = ST_OK;
			end else if (tbl_made < NUM_TABLES) begin
				r.table_out = TID_W'(tbl_made);
				tbl_made++;
				r.status = ST_OK;
			end else begin
				r.status = ST_EXHAUSTED;
			end
		end
		CMD_DESTROY: begin
			if (known && free_depth < NUM_TABLES) begin
				foreach (page_off[k])
					if ((k >> PAGE_BITS) == 32'(tid))
						doomed.push_back(k);
				foreach (doomed[i]) begin
					page_off.delete(doomed[i]);
					page_prot.delete(doomed[i]);
				end
				free_ids[free_depth] = tid;
				free_depth++;
				r.status = ST_OK;
			end
		end
		CMD_LOAD: begin
			if (known) begin
				cur_table = tid;
				r.status = ST_OK;
			end
		end
		CMD_MAP: begin
			if (!known || (c.vaddr & PAGE_MASK) != 0 || (c.phys_offset & PAGE_MASK) != 0)
				r.status = ST_INVALID;
			else if (34'(c.phys_offset) + PAGE_BYTES > 34'(mem_limit))
				r.status = ST_BADADDR;
			else begin
				page_off[key]  = c.phys_offset;
				page_prot[key] = c.prot;
				r.status = ST_OK;
			end
		end
		CMD_UNMAP, CMD_GET: begin
			if (!known)
				r.status = ST_INVALID;
			else if (!page_off.exists(key))
				r.status = ST_BADADDR;
			else begin
				r.phys_out = page_off[key];
				r.entry_prot = page_prot[key];
				r.status = ST_OK;
				if (c.command == CMD_UNMAP) begin
					page_off.delete(key);
					page_prot.delete(key);
				end
			end
		end
		CMD_TRANSLATE: begin
			key = entry_key(cur_table, c.vaddr);
			if (!page_off.exists(key))
				r.status = ST_FAULT;
			else if (!c.wr_access && !page_prot[key][0])
				r.status = ST_FAULT;
			else if (c.wr_access && !page_prot[key][1])
				r.status = ST_FAULT;
			else begin
				r.phys_out = page_off[key] + (c.vaddr & PAGE_MASK);
				r.status = ST_OK;
			end
		end
		default: r.status = ST_INVALID;
		endcase
		return r;
	endfunction

	// ---------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------
	function automatic void push_cmd(in_t c);
		if (c.command == CMD_CREATE) begin
			if (gen_free > 0)
				gen_free--;
			else if (gen_made < NUM_TABLES)
				gen_made++;
		end else if (c.command == CMD_DESTROY && 32'(c.table_index) < gen_made
				&& gen_free < NUM_TABLES) begin
			gen_free++;
			if (destroys_left > 0)
				destroys_left--;
		end
		cmd_backlog.push_back(c);
		cmds_unanswered++;
	endfunction

	function automatic in_t mk(logic [2:0] cmd, logic [7:0] tid, logic [31:0] va,
			logic [31:0] pa, logic [31:0] pr, logic wr);
		in_t c;
		c.command     = cmd;
		c.table_index = tid;
		c.vaddr       = va;
		c.phys_offset = pa;
		c.prot        = pr;
		c.wr_access   = wr;
		return c;
	endfunction

	// fully random beat; callers override the fields that matter
	function automatic in_t noise_item();
		return mk(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)), $urandom,
			$urandom, $urandom, 1'($urandom_range(0, 1)));
	endfunction

	function automatic logic [7:0] pick_table();
		logic [7:0] t;
		if (gen_made > 0 && $urandom_range(0, 3) != 0)
			t = 8'($urandom_range(0, gen_made - 1));
		else
			t = 8'($urandom_range(0, 255));
		return t;
	endfunction

	// a few pages get reused so maps and lookups meet; the rest spread wide
	function automatic logic [31:0] pick_page();
		logic [31:0] p;
		case ($urandom_range(0, 5))
		0:       p = '0;
		1:       p = (32'd1 << PAGE_BITS) - 1;
		2, 3:    p = 32'($urandom_range(0, 7));
		default: p = $urandom >> PAGE_SHIFT;
		endcase
		return p;
	endfunction

	// physical offsets cluster around the current memory bound
	function automatic logic [31:0] pick_offset();
		logic [32:0] top;
		logic [31:0] pg;
		top = (gen_mem < 33'(PAGE_BYTES)) ? '0 : (gen_mem - 33'(PAGE_BYTES)) >> PAGE_SHIFT;
		if (top > (33'd1 << PAGE_BITS) - 1)
			top = (33'd1 << PAGE_BITS) - 1;
		case ($urandom_range(0, 4))
		0:       pg = top[31:0];
		1:       pg = top[31:0] + 1;      // first page past the bound
		2:       pg = $urandom >> PAGE_SHIFT;
		default: pg = $urandom_range(0, top[31:0]);
		endcase
		return pg << PAGE_SHIFT;
	endfunction

	// map a page, maybe make its table active, touch it, then read it back
	function automatic int add_sequence();
		in_t c;
		logic [7:0] tid;
		logic [31:0] va;
		int n;
		tid = pick_table();
		va = pick_page() << PAGE_SHIFT;
		c = noise_item();
		c.command = CMD_MAP;
		c.table_index = tid;
		c.vaddr = va;
		c.phys_offset = pick_offset();
		if ($urandom_range(0, 1))
			c.prot[1:0] = 2'b11;
		push_cmd(c);
		n = 1;
		if ($urandom_range(0, 1)) begin
			c = noise_item();
			c.command = CMD_LOAD;
			c.table_index = tid;
			push_cmd(c);
			n++;
		end
		repeat ($urandom_range(1, 4)) begin
			c = noise_item();
			c.command = CMD_TRANSLATE;
			c.vaddr = va | ($urandom & PAGE_MASK);
			push_cmd(c);
			n++;
		end
		c = noise_item();
		c.command = ($urandom_range(0, 2) == 0) ? CMD_UNMAP : CMD_GET;
		c.table_index = tid;
		c.vaddr = va | ($urandom & PAGE_MASK);
		push_cmd(c);
		return n + 1;
	endfunction

	function automatic void add_single();
		in_t c;
		c = noise_item();
		c.table_index = pick_table();
		case ($urandom_range(0, 19))
		0, 1: c.command = CMD_CREATE;
		2, 3: begin
			c.command = CMD_DESTROY;
			// out of sweep budget: aim at an id that was never handed out
			if (destroys_left == 0)
				c.table_index = 8'($urandom_range(NUM_TABLES, 255));
		end
		4, 5: c.command = CMD_LOAD;
		6:    c.command = CMD_UNUSED;
		7, 8, 9: begin
			c.command = CMD_MAP;
			c.vaddr = pick_page() << PAGE_SHIFT;
			c.phys_offset = pick_offset();
			case ($urandom_range(0, 5))
			0:       c.vaddr |= $urandom_range(1, PAGE_MASK);
			1:       c.phys_offset |= $urandom_range(1, PAGE_MASK);
			default: ;
			endcase
		end
		10, 11, 12, 13: begin
			c.command = ($urandom_range(0, 1)) ? CMD_UNMAP : CMD_GET;
			c.vaddr = (pick_page() << PAGE_SHIFT) | ($urandom & PAGE_MASK);
		end
		default: begin
			c.command = CMD_TRANSLATE;
			c.vaddr = (pick_page() << PAGE_SHIFT) | ($urandom & PAGE_MASK);
		end
		endcase
		push_cmd(c);
	endfunction

	task automatic fill_random(int n);
		int made;
		made = 0;
		while (made < n) begin
			if ($urandom_range(0, 9) < 7)
				made += add_sequence();
			else begin
				add_single();
				made++;
			end
		end
	endtask

	// memory size is only written with the block idle
	task automatic write_mem_size(logic [MEM_BYTES_W-1:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(negedge clk); while (!cfg_fire);
		cfg_valid <= 1'b0;
		gen_mem = v;
	endtask

	// sender pause: nothing new until every result is back, then a few
	// spare cycles before the next register write
	task automatic drain();
		while (cmds_unanswered != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic mem_phase(logic [MEM_BYTES_W-1:0] v, int n, bit hold_rx);
		write_mem_size(v);
		@(posedge clk);
		fill_random(n);
		if (hold_rx)
			stall_req = 1'b1;
		drain();
	endtask

	// ---------------------------------------------------------------
	// Driver: presents command beats at the falling edge. Works in bursts
	// of random length separated by random gaps; a beat stays put until
	// the rising edge that takes it.
	// ---------------------------------------------------------------
	always @(negedge clk) begin : drive_cmds
		logic nxt_valid;
		in_t  nxt_data;
		nxt_valid = in_valid;
		nxt_data = in_data;
		if (!arst_n)
			nxt_valid = 1'b0;
		else if (!in_valid || in_fire) begin
			nxt_valid = 1'b0;
			if (gap_left > 0)
				gap_left--;
			else if (cmd_backlog.size() > 0) begin
				nxt_data = cmd_backlog.pop_front();
				nxt_valid = 1'b1;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 32);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left--;
				end
			end
		end
		in_valid <= nxt_valid;
		in_data <= nxt_data;
	end

	// Receiver: ready pattern switches between modes every so often. Once,
	// on request, it holds ready low through a long stall so the block backs up
	// and drops in_ready while the driver keeps offering beats.
	always @(negedge clk) begin : drive_ready
		logic rdy;
		if (stall_req && !stall_seen) begin
			stall_seen = 1'b1;
			stall_left = LONG_STALL;
		end
		if (mode_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			mode_left = $urandom_range(20, 150);
		end else begin
			mode_left--;
		end
		if (stall_left > 0) begin
			stall_left--;
			rdy = 1'b0;
		end else begin
			case (rx_mode)
			RX_STREAM: rdy = 1'b1;
			RX_COIN:   rdy = 1'($urandom_range(0, 1));
			RX_SPARSE: rdy = ($urandom_range(0, 3) == 0);
			default:   rdy = ($urandom_range(0, 7) != 0);
			endcase
		end
		out_ready <= rdy;
	end

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatches++;
		end
	endtask

	// ---------------------------------------------------------------
	// Monitor: at each rising edge, checks a result beat against the
	// oldest expectation, then feeds an accepted command beat or
	// register write to the predictor.
	// ---------------------------------------------------------------
	always @(posedge clk) begin : watch_beats
		out_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (outcome_q.size() == 0) begin
					$error("unexpected result beat, status %0d", out_data.status);
					mismatches++;
				end else begin
					want = outcome_q.pop_front();
					cmds_unanswered--;
					check_field("status", 32'(want.status), 32'(out_data.status));
					check_field("table_out", 32'(want.table_out), 32'(out_data.table_out));
					check_field("phys_out", want.phys_out, out_data.phys_out);
					check_field("entry_prot", want.entry_prot, out_data.entry_prot);
				end
			end
			if (in_valid && in_ready)
				outcome_q.push_back(page_table_outcome(in_data));
			if (cfg_valid && cfg_ready)
				mem_limit = cfg_data;
		end
		in_fire <= arst_n && in_valid && in_ready;
		cfg_fire <= arst_n && cfg_valid && cfg_ready;
	end

	// Watchdog: a run of cycles with no beat on any channel means a hang.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Sequence of the run
	// ---------------------------------------------------------------
	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part at the reset memory size (2^32).
		write_mem_size(MEM_BYTES_RST);
		@(posedge clk);
		// nothing created yet: translate faults, table ops are invalid
		push_cmd(mk(CMD_TRANSLATE, 8'd0, 32'h0000_0000, '0, '0, 1'b0));
		push_cmd(mk(CMD_MAP, 8'd0, 32'h0000_0000, 32'h0000_0000, 32'h3, 1'b0));
		push_cmd(mk(CMD_UNUSED, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
		push_cmd(mk(CMD_CREATE, 8'd0, '0, '0, '0, 1'b0));
		// last page, placed flush against the top of memory
		push_cmd(mk(CMD_MAP, 8'd0, 32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_FFFF, 1'b0));
		// misaligned virtual, then misaligned physical
		push_cmd(mk(CMD_MAP, 8'd0, 32'h0001_0001, 32'h0000_0000, 32'h3, 1'b0));
		push_cmd(mk(CMD_MAP, 8'd0, 32'h0002_0000, 32'h0000_0001, 32'h3, 1'b0));
		push_cmd(mk(CMD_LOAD, 8'd0, '0, '0, '0, 1'b0));
		// read-only page: write faults, read passes
		push_cmd(mk(CMD_MAP, 8'd0, 32'h0000_0000, 32'h0000_0000, 32'h1, 1'b0));
		push_cmd(mk(CMD_TRANSLATE, 8'd0, 32'h0000_1234, '0, '0, 1'b1));
		push_cmd(mk(CMD_TRANSLATE, 8'd0, 32'h0000_1234, '0, '0, 1'b0));
		push_cmd(mk(CMD_GET, 8'd0, 32'h0000_ABCD, '0, '0, 1'b0));
		push_cmd(mk(CMD_UNMAP, 8'd0, 32'h0000_0000, '0, '0, 1'b0));
		push_cmd(mk(CMD_UNMAP, 8'd0, 32'h0000_0000, '0, '0, 1'b0));
		repeat (3) push_cmd(mk(CMD_CREATE, 8'd0, '0, '0, '0, 1'b0));
		// same id destroyed twice, then fill the free stack and overflow it
		push_cmd(mk(CMD_DESTROY, 8'd1, '0, '0, '0, 1'b0));
		push_cmd(mk(CMD_DESTROY, 8'd1, '0, '0, '0, 1'b0));
		push_cmd(mk(CMD_DESTROY, 8'd2, '0, '0, '0, 1'b0));
		push_cmd(mk(CMD_DESTROY, 8'd3, '0, '0, '0, 1'b0));
		push_cmd(mk(CMD_DESTROY, 8'd0, '0, '0, '0, 1'b0));
		// pops come back last-in first; the fifth finds nothing left
		repeat (5) push_cmd(mk(CMD_CREATE, 8'd0, '0, '0, '0, 1'b0));
		drain();

		// Random part across memory sizes; every destroy is a full sweep,
		// so only a couple may succeed.
		destroys_left = 2;
		mem_phase(33'd0, 100, 1'b0);
		mem_phase(33'h1_FFFF_FFFF, 180, 1'b1);
		mem_phase(33'h0_0001_0000, 100, 1'b0);
		mem_phase({1'b0, $urandom}, 150, 1'b0);
		mem_phase(MEM_BYTES_RST, 120, 1'b0);

		repeat (20) @(negedge clk);
		if (mismatches == 0 && outcome_q.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
